>>> src/jaf_pkg.sv
`default_nettype none
package jaf_pkg;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_F1,
    S_F2,
    S_SPR,
    S_DMP,
    S_VMUL,
    S_VADD,
    S_PMUL,
    S_PADD,
    S_OUT
  } state_t;

  // register indexes on the configuration port
  localparam logic [2:0] REG_TIME_STEP     = 3'd0;
  localparam logic [2:0] REG_FILTER_WEIGHT = 3'd1;
  localparam logic [2:0] REG_POS_LIMIT     = 3'd2;
  localparam logic [2:0] REG_VEL_LIMIT     = 3'd3;
  localparam logic [2:0] REG_STIFF_PROX    = 3'd4;
  localparam logic [2:0] REG_STIFF_DIST    = 3'd5;
  localparam logic [2:0] REG_DAMP_PROX     = 3'd6;
  localparam logic [2:0] REG_DAMP_DIST     = 3'd7;

  // input actions
  localparam logic ACT_UPDATE    = 1'b0;
  localparam logic ACT_CALIBRATE = 1'b1;

  // joints below this index use the proximal gains and unit inverse mass
  localparam logic [2:0] PROXIMAL_COUNT = 3'd3;

  // shared multiplier operand and product widths
  localparam int OpW   = 33;
  localparam int ProdW = 2 * OpW;

  // port widths
  localparam int InDataW  = 136;
  localparam int OutDataW = 104;
  localparam int CfgW     = 31;

  // reset values of the registers
  localparam logic [24:0] TIME_STEP_RST     = 25'd16777;
  localparam logic [16:0] FILTER_WEIGHT_RST = 17'd45875;
  localparam logic [30:0] POS_LIMIT_RST     = 31'd22938;
  localparam logic [30:0] VEL_LIMIT_RST     = 31'd65536;
  localparam logic [25:0] STIFF_PROX_RST    = 26'd6553600;
  localparam logic [25:0] STIFF_DIST_RST    = 26'd2621440;
  localparam logic [25:0] DAMP_PROX_RST     = 26'd3276800;
  localparam logic [25:0] DAMP_DIST_RST     = 26'd1310720;

  // saturate a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [ProdW-1:0] v);
    logic signed [ProdW-1:0] hi;
    logic signed [ProdW-1:0] lo;
    hi = ProdW'(signed'(32'sh7fffffff));
    lo = ProdW'(signed'(32'sh80000000));
    if (v > hi) begin
      return 32'sh7fffffff;
    end else if (v < lo) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

  // symmetric clamp to +-lim
  function automatic logic signed [31:0] clamp_sym(input logic signed [31:0] v,
                                                   input logic [30:0] lim);
    logic signed [31:0] lim_s;
    lim_s = signed'({1'b0, lim});
    if (v > lim_s) begin
      return lim_s;
    end else if (v < -lim_s) begin
      return -lim_s;
    end else begin
      return v;
    end
  endfunction

endpackage
`default_nettype wire

>>> src/joint_admittance_filter.sv
`default_nettype none
// sequence: an update request steps S_LOAD, S_F1, S_F2, S_SPR, S_DMP, S_VMUL, S_VADD,
//   S_PMUL, S_PADD, S_OUT; a calibrate or out-of-range request goes from S_LOAD to S_OUT
// issue: a request is taken only in S_IDLE, after S_OUT loads the last result; the steps
//   share the single 33x33 multiplier whose registered product feeds each following step
// reset: synchronous active-low rst_n restores register defaults, clears all per-joint state
module joint_admittance_filter #(
  parameter int JOINTS = 6
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // configuration write port
  input  wire logic                         cfg_we,
  input  wire logic [2:0]                   cfg_index,
  input  wire logic [jaf_pkg::CfgW-1:0]     cfg_wdata,
  // request channel
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  // joint[2:0], measured_torque[34:3], model_torque[66:35],
  // reference_position[98:67], reference_velocity[130:99], zero pad[135:131]
  input  wire logic [jaf_pkg::InDataW-1:0]  in_tdata,
  // action[0]
  input  wire logic                         in_tuser,
  // result channel
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  // joint_out[2:0], target_position[34:3], target_velocity[66:35],
  // filtered_torque[98:67], zero pad[103:99]
  output logic [jaf_pkg::OutDataW-1:0]      out_tdata
);

  localparam int JW = (JOINTS > 1) ? $clog2(JOINTS) : 1;
  localparam int AW = 50;

  // configuration registers
  logic [24:0] time_step_r;
  logic [16:0] filter_weight_r;
  logic [30:0] pos_limit_r;
  logic [30:0] vel_limit_r;
  logic [25:0] stiff_prox_r;
  logic [25:0] stiff_dist_r;
  logic [25:0] damp_prox_r;
  logic [25:0] damp_dist_r;

  // per-joint state
  logic signed [31:0] bias_r     [JOINTS];
  logic signed [31:0] smoothed_r [JOINTS];
  logic signed [31:0] poff_r     [JOINTS];
  logic signed [31:0] voff_r     [JOINTS];

  // sequencer and request capture
  jaf_pkg::state_t state_r, state_nxt;
  logic               action_r;
  logic [2:0]         joint_r;
  logic signed [31:0] meas_r, model_r, rpos_r, rvel_r;

  // working registers
  logic signed [31:0]           ext_r, pos_r, vel_r, filt_r, accel_r, v_r;
  logic signed [AW-1:0]         acc_r;
  logic signed [jaf_pkg::ProdW-1:0] prod_r;

  // output register
  logic                          out_tvalid_r;
  logic [jaf_pkg::OutDataW-1:0]  out_tdata_r;

  // decoded controls
  logic in_accept, out_load;

  logic [JW-1:0]  jidx;
  logic           in_range, prox;
  logic [16:0]    w_eff, w_inv;
  logic [24:0]    dt_eff;
  logic [25:0]    k_sel, d_sel;

  assign jidx     = JW'(joint_r);
  assign in_range = ({2'b00, joint_r} < 5'(JOINTS));
  assign prox     = (joint_r < jaf_pkg::PROXIMAL_COUNT);
  assign w_eff    = (filter_weight_r > 17'd65536) ? 17'd65536 : filter_weight_r;
  assign w_inv    = 17'd65536 - w_eff;
  assign dt_eff   = (time_step_r > 25'd16777216) ? 25'd16777216 : time_step_r;
  assign k_sel    = prox ? stiff_prox_r : stiff_dist_r;
  assign d_sel    = prox ? damp_prox_r : damp_dist_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_step_r     <= jaf_pkg::TIME_STEP_RST;
      filter_weight_r <= jaf_pkg::FILTER_WEIGHT_RST;
      pos_limit_r     <= jaf_pkg::POS_LIMIT_RST;
      vel_limit_r     <= jaf_pkg::VEL_LIMIT_RST;
      stiff_prox_r    <= jaf_pkg::STIFF_PROX_RST;
      stiff_dist_r    <= jaf_pkg::STIFF_DIST_RST;
      damp_prox_r     <= jaf_pkg::DAMP_PROX_RST;
      damp_dist_r     <= jaf_pkg::DAMP_DIST_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        jaf_pkg::REG_TIME_STEP:     time_step_r     <= cfg_wdata[24:0];
        jaf_pkg::REG_FILTER_WEIGHT: filter_weight_r <= cfg_wdata[16:0];
        jaf_pkg::REG_POS_LIMIT:     pos_limit_r     <= cfg_wdata[30:0];
        jaf_pkg::REG_VEL_LIMIT:     vel_limit_r     <= cfg_wdata[30:0];
        jaf_pkg::REG_STIFF_PROX:    stiff_prox_r    <= cfg_wdata[25:0];
        jaf_pkg::REG_STIFF_DIST:    stiff_dist_r    <= cfg_wdata[25:0];
        jaf_pkg::REG_DAMP_PROX:     damp_prox_r     <= cfg_wdata[25:0];
        jaf_pkg::REG_DAMP_DIST:     damp_dist_r     <= cfg_wdata[25:0];
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      jaf_pkg::S_IDLE: if (in_tvalid) state_nxt = jaf_pkg::S_LOAD;
      jaf_pkg::S_LOAD: begin
        if (!in_range || action_r == jaf_pkg::ACT_CALIBRATE) begin
          state_nxt = jaf_pkg::S_OUT;
        end else begin
          state_nxt = jaf_pkg::S_F1;
        end
      end
      jaf_pkg::S_F1:   state_nxt = jaf_pkg::S_F2;
      jaf_pkg::S_F2:   state_nxt = jaf_pkg::S_SPR;
      jaf_pkg::S_SPR:  state_nxt = jaf_pkg::S_DMP;
      jaf_pkg::S_DMP:  state_nxt = jaf_pkg::S_VMUL;
      jaf_pkg::S_VMUL: state_nxt = jaf_pkg::S_VADD;
      jaf_pkg::S_VADD: state_nxt = jaf_pkg::S_PMUL;
      jaf_pkg::S_PMUL: state_nxt = jaf_pkg::S_PADD;
      jaf_pkg::S_PADD: state_nxt = jaf_pkg::S_OUT;
      jaf_pkg::S_OUT:  if (!out_tvalid_r || out_tready) state_nxt = jaf_pkg::S_IDLE;
      default:         state_nxt = jaf_pkg::S_IDLE;
    endcase
  end

  // handshake outputs of the sequencer
  always_comb begin
    in_tready = (state_r == jaf_pkg::S_IDLE);
    out_load  = (state_r == jaf_pkg::S_OUT) && (!out_tvalid_r || out_tready);
  end

  assign in_accept = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= jaf_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // capture the request
  always_ff @(posedge clk) begin
    if (in_accept) begin
      action_r <= in_tuser;
      joint_r  <= in_tdata[2:0];
      meas_r   <= in_tdata[34:3];
      model_r  <= in_tdata[66:35];
      rpos_r   <= in_tdata[98:67];
      rvel_r   <= in_tdata[130:99];
    end
  end

  // shared multiplier operand select
  logic signed [jaf_pkg::OpW-1:0] op_a, op_b;

  always_comb begin
    unique case (state_r)
      jaf_pkg::S_LOAD: begin
        op_a = jaf_pkg::OpW'(smoothed_r[jidx]);
        op_b = signed'({16'b0, w_eff});
      end
      jaf_pkg::S_F1: begin
        op_a = jaf_pkg::OpW'(ext_r);
        op_b = signed'({16'b0, w_inv});
      end
      jaf_pkg::S_F2: begin
        op_a = jaf_pkg::OpW'(pos_r);
        op_b = signed'({7'b0, k_sel});
      end
      jaf_pkg::S_SPR: begin
        op_a = jaf_pkg::OpW'(vel_r);
        op_b = signed'({7'b0, d_sel});
      end
      jaf_pkg::S_VMUL: begin
        op_a = jaf_pkg::OpW'(accel_r);
        op_b = signed'({8'b0, dt_eff});
      end
      jaf_pkg::S_PMUL: begin
        op_a = jaf_pkg::OpW'(v_r);
        op_b = signed'({8'b0, dt_eff});
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // registered product
  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

  // datapath steps around the multiplier
  logic signed [33:0]               ext_sum, cal_sum;
  logic signed [AW-1:0]             fsum, dsum, dsum2;
  logic signed [jaf_pkg::ProdW-1:0] vsum, psum;
  logic signed [31:0]               p_new;

  always_comb begin
    ext_sum = 34'(meas_r) - 34'(model_r) - 34'(bias_r[jidx]);
    cal_sum = 34'(meas_r) - 34'(model_r);
    fsum    = acc_r + AW'(prod_r);
    dsum    = acc_r - AW'(prod_r >>> 16);
    dsum2   = prox ? dsum : (dsum <<< 1);
    vsum    = jaf_pkg::ProdW'(vel_r) + (prod_r >>> 24);
    psum    = jaf_pkg::ProdW'(pos_r) + (prod_r >>> 24);
    p_new   = jaf_pkg::sat32(psum);
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      jaf_pkg::S_LOAD: begin
        ext_r <= jaf_pkg::sat32(jaf_pkg::ProdW'(ext_sum));
        if (!in_range) begin
          pos_r  <= '0;
          vel_r  <= '0;
          filt_r <= '0;
        end else begin
          pos_r <= poff_r[jidx];
          vel_r <= voff_r[jidx];
          if (action_r == jaf_pkg::ACT_CALIBRATE) begin
            filt_r <= jaf_pkg::sat32(jaf_pkg::ProdW'(cal_sum));
          end
        end
      end
      jaf_pkg::S_F1:   acc_r   <= AW'(prod_r);
      jaf_pkg::S_F2:   filt_r  <= jaf_pkg::sat32(jaf_pkg::ProdW'(fsum >>> 16));
      jaf_pkg::S_SPR:  acc_r   <= AW'(filt_r) - AW'(prod_r >>> 16);
      jaf_pkg::S_DMP:  accel_r <= jaf_pkg::sat32(jaf_pkg::ProdW'(dsum2));
      jaf_pkg::S_VADD: v_r     <= jaf_pkg::sat32(vsum);
      jaf_pkg::S_PADD: begin
        pos_r <= jaf_pkg::clamp_sym(p_new, pos_limit_r);
        vel_r <= jaf_pkg::clamp_sym(v_r, vel_limit_r);
      end
      default: begin
      end
    endcase
  end

  // per-joint state write-back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < JOINTS; i++) begin
        bias_r[i]     <= '0;
        smoothed_r[i] <= '0;
        poff_r[i]     <= '0;
        voff_r[i]     <= '0;
      end
    end else if (in_range) begin
      if (state_r == jaf_pkg::S_LOAD && action_r == jaf_pkg::ACT_CALIBRATE) begin
        bias_r[jidx]     <= jaf_pkg::sat32(jaf_pkg::ProdW'(cal_sum));
        smoothed_r[jidx] <= jaf_pkg::sat32(jaf_pkg::ProdW'(cal_sum));
      end
      if (state_r == jaf_pkg::S_F2) begin
        smoothed_r[jidx] <= jaf_pkg::sat32(jaf_pkg::ProdW'(fsum >>> 16));
      end
      if (state_r == jaf_pkg::S_PADD) begin
        poff_r[jidx] <= jaf_pkg::clamp_sym(p_new, pos_limit_r);
        voff_r[jidx] <= jaf_pkg::clamp_sym(v_r, vel_limit_r);
      end
    end
  end

  // result assembly and output register
  logic signed [31:0] tpos, tvel;

  always_comb begin
    tpos = jaf_pkg::sat32(jaf_pkg::ProdW'(rpos_r) + jaf_pkg::ProdW'(pos_r));
    tvel = jaf_pkg::sat32(jaf_pkg::ProdW'(rvel_r) + jaf_pkg::ProdW'(vel_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tdata_r <= {5'b0, filt_r, tvel, tpos, joint_r};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule
`default_nettype wire

>>> src/jaf_checker.sv
`default_nettype none
module jaf_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tvalid,
  input wire logic         in_tready,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [103:0] out_tdata
);

  // the sequencer is busy right after taking a request
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("in_tready high right after an accepted request");

  // a result only appears out of a busy cycle
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result appeared while the sequencer was idle");

  // reset leaves no stale result
  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("out_tvalid high after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed or dropped");

endmodule

bind joint_admittance_filter jaf_checker u_jaf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire

>>> dv/joint_admittance_filter_tb.sv
`default_nettype none
module joint_admittance_filter_tb;

  localparam int JOINTS = 6;
  localparam int PHASES = 7;
  localparam int ITEMS_PER_PHASE = 220;
  localparam int DRAIN_CYCLES = 14;
  localparam int STALL_LIMIT = 2000;
  localparam logic signed [31:0] WORD_HI = 32'sh7fff_ffff;
  localparam logic signed [31:0] WORD_LO = 32'sh8000_0000;
  localparam longint WORD_MAX = 64'sd2147483647;
  localparam longint WORD_MIN = -64'sd2147483648;

  typedef struct {
    logic               action;
    logic [2:0]         joint;
    logic signed [31:0] measured;
    logic signed [31:0] model;
    logic signed [31:0] ref_pos;
    logic signed [31:0] ref_vel;
  } joint_request_t;

  typedef struct {
    logic [2:0]         joint;
    logic signed [31:0] target_pos;
    logic signed [31:0] target_vel;
    logic signed [31:0] filtered;
  } joint_target_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         cfg_we = 1'b0;
  logic [2:0]                   cfg_index = '0;
  logic [jaf_pkg::CfgW-1:0]     cfg_wdata = '0;
  logic                         in_tvalid = 1'b0;
  logic                         in_tready;
  logic [jaf_pkg::InDataW-1:0]  in_tdata = '0;
  logic                         in_tuser = 1'b0;
  logic                         out_tvalid;
  logic                         out_tready = 1'b0;
  logic [jaf_pkg::OutDataW-1:0] out_tdata;

  // predictor copy of the registers
  logic [24:0] dt_reg = jaf_pkg::TIME_STEP_RST;
  logic [16:0] weight_reg = jaf_pkg::FILTER_WEIGHT_RST;
  logic [30:0] pos_limit_reg = jaf_pkg::POS_LIMIT_RST;
  logic [30:0] vel_limit_reg = jaf_pkg::VEL_LIMIT_RST;
  logic [25:0] stiff_prox_reg = jaf_pkg::STIFF_PROX_RST;
  logic [25:0] stiff_dist_reg = jaf_pkg::STIFF_DIST_RST;
  logic [25:0] damp_prox_reg = jaf_pkg::DAMP_PROX_RST;
  logic [25:0] damp_dist_reg = jaf_pkg::DAMP_DIST_RST;

  // predictor copy of the per-joint state
  logic signed [31:0] bias_mem [JOINTS];
  logic signed [31:0] smooth_mem [JOINTS];
  logic signed [31:0] pos_mem [JOINTS];
  logic signed [31:0] vel_mem [JOINTS];

  joint_request_t joint_requests [$];
  joint_target_t  expected_targets [$];
  joint_request_t active_request;
  joint_target_t  want;
  int             requests_left = 0;
  int             failures = 0;
  int             cycle_count = 0;
  int             stall_cycles = 0;
  logic           quiet_window;

  joint_admittance_filter #(.JOINTS(JOINTS)) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    // joint, measured_torque, model_torque, reference_position, reference_velocity, pad
    .in_tdata   (in_tdata),
    // action
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    // joint_out, target_position, target_velocity, filtered_torque, pad
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  // a stretch of cycles with no idling on either side
  assign quiet_window = (cycle_count[13:11] == 3'd3);

  function automatic bit take_break();
    return !quiet_window && ($urandom_range(0, 99) < 10);
  endfunction

  function automatic logic signed [31:0] sat_word(input longint v);
    if (v > WORD_MAX) return WORD_HI;
    if (v < WORD_MIN) return WORD_LO;
    return 32'(v);
  endfunction

  function automatic logic signed [31:0] clamp_word(input longint v, input logic [30:0] lim);
    longint bound;
    bound = lim;
    if (v > bound) return 32'(bound);
    if (v < -bound) return 32'(-bound);
    return 32'(v);
  endfunction

  // expected target for one request, advancing the joint state
  function automatic joint_target_t admittance_predict(input joint_request_t rq);
    joint_target_t t;
    longint dt, w, k, d, ext, filt, spring, damper, acc, pos, vel;
    bit prox;
    t.joint = rq.joint;
    t.filtered = '0;
    pos = 0;
    vel = 0;
    if (rq.joint < JOINTS) begin
      if (rq.action == jaf_pkg::ACT_CALIBRATE) begin
        bias_mem[rq.joint] = sat_word(longint'(rq.measured) - longint'(rq.model));
        smooth_mem[rq.joint] = bias_mem[rq.joint];
      end else begin
        dt = dt_reg;
        if (dt > 64'sd16777216) dt = 64'sd16777216;
        w = weight_reg;
        if (w > 64'sd65536) w = 64'sd65536;
        prox = rq.joint < jaf_pkg::PROXIMAL_COUNT;
        k = prox ? stiff_prox_reg : stiff_dist_reg;
        d = prox ? damp_prox_reg : damp_dist_reg;
        ext = sat_word(longint'(rq.measured) - longint'(rq.model)
                       - longint'(bias_mem[rq.joint]));
        filt = (w * longint'(smooth_mem[rq.joint]) + (64'sd65536 - w) * ext) >>> 16;
        smooth_mem[rq.joint] = sat_word(filt);
        pos = pos_mem[rq.joint];
        vel = vel_mem[rq.joint];
        spring = (k * pos) >>> 16;
        damper = (d * vel) >>> 16;
        acc = longint'(smooth_mem[rq.joint]) - damper - spring;
        // distal joints have half the mass
        if (!prox) acc = acc * 2;
        acc = sat_word(acc);
        vel = sat_word(vel + ((acc * dt) >>> 24));
        pos = sat_word(pos + ((vel * dt) >>> 24));
        vel_mem[rq.joint] = clamp_word(vel, vel_limit_reg);
        pos_mem[rq.joint] = clamp_word(pos, pos_limit_reg);
      end
      pos = pos_mem[rq.joint];
      vel = vel_mem[rq.joint];
      t.filtered = smooth_mem[rq.joint];
    end
    t.target_pos = sat_word(longint'(rq.ref_pos) + pos);
    t.target_vel = sat_word(longint'(rq.ref_vel) + vel);
    return t;
  endfunction

  function automatic logic signed [31:0] pick_word();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: begin
        case ($urandom_range(0, 3))
          0: return WORD_HI;
          1: return WORD_LO;
          2: return 32'sd0;
          default: return -32'sd1;
        endcase
      end
      default: return $signed($urandom_range(0, 32'h1f_ffff)) - 32'sh10_0000;
    endcase
  endfunction

  task automatic queue_request(input logic action, input logic [2:0] joint,
                               input logic signed [31:0] measured, model, ref_pos, ref_vel);
    joint_request_t rq;
    rq.action = action;
    rq.joint = joint;
    rq.measured = measured;
    rq.model = model;
    rq.ref_pos = ref_pos;
    rq.ref_vel = ref_vel;
    joint_requests.insert(joint_requests.size(), rq);
    requests_left++;
  endtask

  // control ticks over all joints with random content, plus some noise
  task automatic queue_random_ticks(input int count);
    int queued;
    logic signed [31:0] model;
    logic signed [31:0] measured;
    queued = 0;
    while (queued < count) begin
      if ($urandom_range(0, 19) == 0) begin
        queue_request(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), pick_word(),
                      pick_word(), pick_word(), pick_word());
        queued++;
      end else begin
        for (int j = 0; j < JOINTS; j++) begin
          model = pick_word();
          measured = ($urandom_range(0, 3) != 0) ?
                     model + $signed($urandom_range(0, 32'h7_ffff)) - 32'sh4_0000 : pick_word();
          queue_request(($urandom_range(0, 24) == 0) ? jaf_pkg::ACT_CALIBRATE :
                        jaf_pkg::ACT_UPDATE, 3'(j), measured, model, pick_word(), pick_word());
          queued++;
        end
      end
    end
  endtask

  task automatic write_register(input logic [2:0] idx, input logic [30:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      jaf_pkg::REG_TIME_STEP:     dt_reg = value[24:0];
      jaf_pkg::REG_FILTER_WEIGHT: weight_reg = value[16:0];
      jaf_pkg::REG_POS_LIMIT:     pos_limit_reg = value;
      jaf_pkg::REG_VEL_LIMIT:     vel_limit_reg = value;
      jaf_pkg::REG_STIFF_PROX:    stiff_prox_reg = value[25:0];
      jaf_pkg::REG_STIFF_DIST:    stiff_dist_reg = value[25:0];
      jaf_pkg::REG_DAMP_PROX:     damp_prox_reg = value[25:0];
      default:                    damp_dist_reg = value[25:0];
    endcase
  endtask

  // register value for one phase: all ones, all zeros, exact top of time step and weight, then random
  function automatic logic [30:0] phase_setting(input int phase, input logic [2:0] idx);
    logic [30:0] full;
    int width;
    case (idx)
      jaf_pkg::REG_TIME_STEP:                         width = 25;
      jaf_pkg::REG_FILTER_WEIGHT:                     width = 17;
      jaf_pkg::REG_POS_LIMIT, jaf_pkg::REG_VEL_LIMIT: width = 31;
      default:                                        width = 26;
    endcase
    full = 31'((64'd1 << width) - 1);
    case (phase)
      1: return '1;
      2: return '0;
      3: begin
        if (idx == jaf_pkg::REG_TIME_STEP) return 31'd16777216;
        if (idx == jaf_pkg::REG_FILTER_WEIGHT) return 31'd65536;
        return 31'($urandom) & full;
      end
      default: begin
        case ($urandom_range(0, 3))
          0: return 31'($urandom);
          1: return 31'($urandom) & full;
          2: return (31'($urandom) & full) >> $urandom_range(0, width - 1);
          default: return $urandom_range(0, 1) ? full : '0;
        endcase
      end
    endcase
  endfunction

  task automatic wait_drained();
    do @(posedge clk); while (requests_left != 0 || expected_targets.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_targets.insert(expected_targets.size(), admittance_predict(active_request));
        requests_left--;
      end
      if (!in_tvalid || in_tready) begin
        if (joint_requests.size() != 0 && !take_break()) begin
          active_request = joint_requests.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {5'b0, active_request.ref_vel, active_request.ref_pos,
                       active_request.model, active_request.measured, active_request.joint};
          in_tuser <= active_request.action;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic signed [31:0] expected_val,
                             input logic signed [31:0] actual_val);
    if (actual_val !== expected_val) begin
      $error("%s expected %0d got %0d", name, expected_val, actual_val);
      failures++;
    end
  endtask

  // result monitor
  always @(posedge clk) begin
    out_tready <= !take_break();
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_targets.size() == 0) begin
        $error("result for joint %0d with no request outstanding", out_tdata[2:0]);
        failures++;
      end else begin
        want = expected_targets.pop_front();
        check_field("joint_out", 32'(want.joint), 32'(out_tdata[2:0]));
        check_field("target_position", want.target_pos, out_tdata[34:3]);
        check_field("target_velocity", want.target_vel, out_tdata[66:35]);
        check_field("filtered_torque", want.filtered, out_tdata[98:67]);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    for (int j = 0; j < JOINTS; j++) begin
      bias_mem[j] = '0;
      smooth_mem[j] = '0;
      pos_mem[j] = '0;
      vel_mem[j] = '0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: torque extremes, calibration, output saturation, joints out of range
    queue_request(jaf_pkg::ACT_UPDATE, 3'd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
    queue_request(jaf_pkg::ACT_CALIBRATE, 3'd0, WORD_HI, WORD_LO, 32'sd100, -32'sd100);
    queue_request(jaf_pkg::ACT_UPDATE, 3'd0, WORD_LO, WORD_HI, WORD_HI, WORD_LO);
    queue_request(jaf_pkg::ACT_UPDATE, 3'd0, WORD_LO, WORD_HI, WORD_LO, WORD_HI);
    queue_request(jaf_pkg::ACT_CALIBRATE, 3'd1, WORD_LO, WORD_HI, 32'sd0, 32'sd0);
    queue_request(jaf_pkg::ACT_UPDATE, 3'd1, WORD_HI, WORD_LO, WORD_LO, WORD_LO);
    queue_request(jaf_pkg::ACT_UPDATE, 3'd1, WORD_HI, WORD_LO, WORD_HI, WORD_HI);
    queue_request(jaf_pkg::ACT_CALIBRATE, 3'd2, 32'sd12345, -32'sd777, 32'sd1, 32'sd1);
    queue_request(jaf_pkg::ACT_UPDATE, 3'd2, 32'sd12345, -32'sd777, 32'sd65536, -32'sd65536);
    queue_request(jaf_pkg::ACT_UPDATE, 3'd3, WORD_HI, 32'sd0, WORD_HI, WORD_HI);
    queue_request(jaf_pkg::ACT_UPDATE, 3'd3, WORD_HI, 32'sd0, WORD_HI, WORD_HI);
    queue_request(jaf_pkg::ACT_UPDATE, 3'd4, WORD_LO, 32'sd0, WORD_LO, WORD_LO);
    queue_request(jaf_pkg::ACT_UPDATE, 3'd4, WORD_LO, 32'sd0, WORD_LO, WORD_LO);
    queue_request(jaf_pkg::ACT_UPDATE, 3'd5, -32'sd1, 32'sd1, -32'sd1, 32'sd1);
    queue_request(jaf_pkg::ACT_CALIBRATE, 3'd5, -32'sd1, -32'sd1, 32'sd0, 32'sd0);
    queue_request(jaf_pkg::ACT_UPDATE, 3'd5, 32'sh0001_0000, 32'sd0, 32'sd0, 32'sd0);
    queue_request(jaf_pkg::ACT_UPDATE, 3'd6, WORD_HI, WORD_LO, WORD_HI, WORD_LO);
    queue_request(jaf_pkg::ACT_CALIBRATE, 3'd7, WORD_LO, WORD_HI, WORD_LO, WORD_HI);
    queue_request(jaf_pkg::ACT_UPDATE, 3'd7, 32'sd5, 32'sd3, 32'sd0, -32'sd1);
    queue_request(jaf_pkg::ACT_UPDATE, 3'd2, 32'sh0010_0000, 32'sd0, 32'sd0, 32'sd0);
    queue_request(jaf_pkg::ACT_UPDATE, 3'd0, 32'sd0, WORD_HI, 32'sd7, 32'sd7);
    wait_drained();

    for (int p = 1; p <= PHASES; p++) begin
      for (int r = 0; r < 8; r++) begin
        write_register(3'(r), phase_setting(p, 3'(r)));
      end
      queue_random_ticks(ITEMS_PER_PHASE);
      wait_drained();
    end

    if (failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
